// ----- rtl/lcsl_pkg.sv -----
// Shared types and constants for the LRU cache set lookup.
// No dependencies; imported by lru_cache_set_lookup, lcsl_checker and the testbench.
package lcsl_pkg;

    localparam int WAYS     = 8;
    localparam int TAG_BITS = 32;
    localparam int TAG_IN_W = 32;
    localparam int CFG_W    = 4;
    localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W    = $clog2(WAYS + 1);

    typedef logic [TAG_IN_W-1:0] tag_in_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [CFG_W-1:0]    cfg_t;
    typedef logic [AGE_W-1:0]    age_t;
    typedef logic [IDX_W-1:0]    way_idx_t;
    typedef logic [CNT_W-1:0]    way_cnt_t;

    localparam age_t AGE_MAX = age_t'(WAYS - 1);

    // Keep the low TAG_BITS bits of the port, zero above the port width.
    function automatic tag_t to_tag(input tag_in_t t);
        tag_t r;
        r = '0;
        for (int i = 0; i < TAG_BITS; i++)
        begin
            if (i < TAG_IN_W)
            begin
                r[i] = t[i];
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/lru_cache_set_lookup.sv -----
// One set of a set-associative cache with true LRU ages: lookup, fill, evict.
// Depends on lcsl_pkg.
//
//  channel | signals                      | direction | transfer
//  --------+------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, tag      | to block  | in_valid && !in_stall
//  out     | out_valid, out_stall, hit    | from block| out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready,        | to block  | cfg_valid && cfg_ready
//          | ways_in_use                  |           |
//
// One item per cycle while the result is not stalled; each item passes from the input register to the result register.
// The lookup, victim choice and age update for all ways sit between the input
// register and the result register; the set state is updated on the same edge.
// Reset: all ways invalid, ways_in_use = 8; no clearing pass.
// A stalled result holds; the input register keeps taking items until it also
// holds an item that cannot move on.
module lru_cache_set_lookup (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lcsl_pkg::tag_in_t tag,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  lcsl_pkg::cfg_t    ways_in_use
);
    import lcsl_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    tag_t              s1_tag_reg;
    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, hit_next;
    cfg_t              ways_reg, ways_next;
    logic [WAYS-1:0]   valid_reg, valid_next;
    age_t              age_reg  [WAYS];
    age_t              age_next [WAYS];
    tag_t              tags_reg [WAYS];

    logic              advance;
    logic              in_accept;
    way_cnt_t          n_eff;
    logic [WAYS-1:0]   active;
    logic              hit_found, free_found, old_found;
    way_idx_t          hit_sel, free_sel, old_sel, sel;
    age_t              old_age, hit_age;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    // Effective associativity: zero acts as one, values above WAYS clamp.
    always_comb
    begin
        if (ways_reg == '0)
        begin
            n_eff = way_cnt_t'(1);
        end
        else if (32'(ways_reg) > 32'(WAYS))
        begin
            n_eff = way_cnt_t'(WAYS);
        end
        else
        begin
            n_eff = way_cnt_t'(ways_reg);
        end
        for (int w = 0; w < WAYS; w++)
        begin
            active[w] = 32'(w) < 32'(n_eff);
        end
    end

    // Hit search, first free way and lowest-numbered oldest way.
    always_comb
    begin
        hit_found  = 1'b0;
        hit_sel    = '0;
        free_found = 1'b0;
        free_sel   = '0;
        old_found  = 1'b0;
        old_sel    = '0;
        old_age    = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (active[w] && valid_reg[w])
            begin
                if (!hit_found && tags_reg[w] == s1_tag_reg)
                begin
                    hit_found = 1'b1;
                    hit_sel   = way_idx_t'(w);
                end
                if (!old_found || age_reg[w] > old_age)
                begin
                    old_found = 1'b1;
                    old_age   = age_reg[w];
                    old_sel   = way_idx_t'(w);
                end
            end
            else if (active[w] && !free_found)
            begin
                free_found = 1'b1;
                free_sel   = way_idx_t'(w);
            end
        end
        if (hit_found)
        begin
            sel = hit_sel;
        end
        else if (free_found)
        begin
            sel = free_sel;
        end
        else
        begin
            sel = old_sel;
        end
        hit_age = age_reg[hit_sel];
    end

    always_comb
    begin
        s1_valid_next  = in_accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
        hit_next       = advance ? hit_found : hit_reg;
        ways_next      = (cfg_valid && cfg_ready) ? ways_in_use : ways_reg;
        valid_next     = valid_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            age_next[w] = age_reg[w];
            if (advance)
            begin
                if (way_idx_t'(w) == sel)
                begin
                    age_next[w]   = '0;
                    valid_next[w] = 1'b1;
                end
                else if (active[w] && valid_reg[w] && age_reg[w] < AGE_MAX
                         && (!hit_found || age_reg[w] < hit_age))
                begin
                    age_next[w] = age_t'(age_reg[w] + age_t'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            ways_reg      <= cfg_t'(8);
            valid_reg     <= '0;
            for (int w = 0; w < WAYS; w++)
            begin
                age_reg[w] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            ways_reg      <= ways_next;
            valid_reg     <= valid_next;
            for (int w = 0; w < WAYS; w++)
            begin
                age_reg[w] <= age_next[w];
            end
        end
    end

    // Payload: input tag and the stored tags.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_tag_reg <= to_tag(tag);
        end
        if (advance && !hit_found)
        begin
            tags_reg[sel] <= s1_tag_reg;
        end
    end

endmodule

// ----- rtl/lcsl_checker.sv -----
// Port-level checks for lru_cache_set_lookup, attached by bind.
// Depends on lcsl_pkg and the top level's ports.
module lcsl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input lcsl_pkg::tag_in_t tag,
    input logic              out_valid,
    input logic              out_stall,
    input logic              hit
);
    import lcsl_pkg::*;

    // A held result keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hit))
        else $error("hit changed while stalled");

    // Input backs up only behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

    // A new result after an empty output comes from an item taken through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching item");

    // A stalled input item holds its valid and tag.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(tag))
        else $error("input item changed while stalled");

endmodule

bind lru_cache_set_lookup lcsl_checker u_lcsl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tag         (tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit)
);

// ----- tb/lru_cache_set_lookup_test.sv -----
// Testbench for lru_cache_set_lookup: directed and random tag streams at several
// associativities, each hit/miss checked against a true-LRU set predictor.
// Depends on lcsl_pkg and the lru_cache_set_lookup RTL.
`timescale 1ns / 100ps

module lru_cache_set_lookup_test;
    import lcsl_pkg::*;

    localparam int NO_WAY      = -1;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 48;
    localparam int POOL_MAX    = 12;

    // Set state mirror: predicts hit/miss per accepted tag, holds pending hit flags.
    class lru_set_scoreboard;
        tag_t way_tag   [WAYS];
        bit   way_vld   [WAYS];
        age_t way_age_q [WAYS];
        int   assoc;
        bit   hit_q [$];
        int   errors;

        function new();
            foreach (way_vld[w])
            begin
                way_tag[w]   = '0;
                way_vld[w]   = 1'b0;
                way_age_q[w] = '0;
            end
            assoc  = WAYS;
            errors = 0;
        endfunction

        function void set_assoc(input cfg_t n);
            if (n == 0)
                assoc = 1;
            else if (int'(n) > WAYS)
                assoc = WAYS;
            else
                assoc = int'(n);
        endfunction

        function void bump_age(input int w);
            if (way_age_q[w] < AGE_MAX)
                way_age_q[w] = way_age_q[w] + 1'b1;
        endfunction

        function int pending();
            return hit_q.size();
        endfunction

        function void note_access(input tag_in_t t);
            tag_t key;
            int   sel;
            age_t old_age;
            key = tag_t'(t);
            sel = NO_WAY;
            for (int w = 0; w < assoc; w++)
            begin
                if (sel == NO_WAY && way_vld[w] && way_tag[w] == key)
                    sel = w;
            end
            if (sel != NO_WAY)
            begin
                old_age = way_age_q[sel];
                for (int w = 0; w < assoc; w++)
                begin
                    if (w != sel && way_vld[w] && way_age_q[w] < old_age)
                        bump_age(w);
                end
                way_age_q[sel] = '0;
                hit_q.push_back(1'b1);
                return;
            end
            // miss: lowest free way, else lowest-numbered among the oldest
            for (int w = 0; w < assoc; w++)
            begin
                if (sel == NO_WAY && !way_vld[w])
                    sel = w;
            end
            if (sel == NO_WAY)
            begin
                sel = 0;
                for (int w = 1; w < assoc; w++)
                begin
                    if (way_age_q[w] > way_age_q[sel])
                        sel = w;
                end
            end
            for (int w = 0; w < assoc; w++)
            begin
                if (w != sel && way_vld[w])
                    bump_age(w);
            end
            way_tag[sel]   = key;
            way_vld[sel]   = 1'b1;
            way_age_q[sel] = '0;
            hit_q.push_back(1'b0);
        endfunction

        function void check_hit(input logic actual);
            bit exp_hit;
            if (hit_q.size() == 0)
            begin
                $error("hit: no access pending, actual %0b", actual);
                errors++;
                return;
            end
            exp_hit = hit_q.pop_front();
            if (actual !== exp_hit)
            begin
                $error("hit: expected %0b, actual %0b", exp_hit, actual);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    tag_in_t tag;
    logic    out_valid;
    logic    out_stall;
    logic    hit;
    logic    cfg_valid;
    logic    cfg_ready;
    cfg_t    ways_in_use;

    lru_set_scoreboard sb;
    bit      idle_on;
    int      stall_left;
    tag_in_t tag_pool [POOL_MAX];

    lru_cache_set_lookup uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .tag         (tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .ways_in_use (ways_in_use)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("lru_cache_set_lookup_test: errors");
        $finish;
    end

    // result side: check accepted items, stall in short random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sb.check_hit(hit);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_tag(input tag_in_t t);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tag      <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_access(t);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_assoc(input cfg_t n);
        cfg_valid   <= 1'b1;
        ways_in_use <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_assoc(n);
    endtask

    initial
    begin
        tag_in_t fill_seq [12];
        int      pool_size;
        sb          = new();
        idle_on     = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        tag         = '0;
        cfg_valid   = 1'b0;
        ways_in_use = cfg_t'(WAYS);
        fill_seq = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5,
                     32'h5A5A_5A5A, 32'h0000_0003, 32'h0000_0004, 32'h0000_0005,
                     32'h0000_0006, 32'hFFFF_FFFF, 32'h0000_0007, 32'h0000_0000};
        foreach (tag_pool[i])
            tag_pool[i] = $urandom();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset associativity: fills, hits, then evictions once the set is full
        foreach (fill_seq[i])
            send_tag(fill_seq[i]);
        in_valid <= 1'b0;
        wait_drained();

        // direct-mapped
        write_assoc(cfg_t'(1));
        send_tag(32'h1234_5678);
        send_tag(32'h1234_5678);
        in_valid <= 1'b0;
        wait_drained();

        // zero acts as one; tag 5 stays hidden in way 6 and gets a second copy in way 0
        write_assoc(cfg_t'(0));
        send_tag(32'h0000_0005);
        in_valid <= 1'b0;
        wait_drained();

        // above WAYS acts as WAYS; hidden ways come back, duplicate resolves to way 0
        write_assoc(cfg_t'(15));
        send_tag(32'h0000_0005);
        send_tag(32'h0000_0006);
        in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p == PHASES - 1)
            begin
                idle_on = 1'b0;
                write_assoc(cfg_t'(WAYS));
            end
            else
            begin
                write_assoc(cfg_t'($urandom_range(0, 15)));
            end
            pool_size = $urandom_range(2, POOL_MAX);
            foreach (tag_pool[i])
            begin
                if ($urandom_range(0, 2) == 0)
                    tag_pool[i] = $urandom();
            end
            // mostly reused tags so hits and evictions dominate, some fresh noise
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_tag(tag_in_t'($urandom()));
                else
                    send_tag(tag_pool[$urandom_range(0, pool_size - 1)]);
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("hit: %0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("lru_cache_set_lookup_test: clean");
        else
            $display("lru_cache_set_lookup_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lcsl_pkg.sv
rtl/lru_cache_set_lookup.sv
rtl/lcsl_checker.sv
tb/lru_cache_set_lookup_test.sv
